@@ sv/vgfc_pkg.sv @@
// shared types and constants of the voxel grid face cull block
package vgfc_pkg;

	localparam int COLOUR_W = 32;
	localparam int COUNT_W  = 13;
	localparam int SIZE_W   = 5;
	localparam int EXT_W    = 7;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [SIZE_W-1:0] SIZE_RST = 5'd10;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_DEL   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [2:0] NB_FIRST = 3'd1;
	localparam logic [2:0] NB_LAST  = 3'd5;
	localparam logic [5:0] MASK_ALL = 6'h3f;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CENTRE,
		ST_CHECK,
		ST_NBR,
		ST_TAIL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]          mode;
		logic [3:0]          x_pos;
		logic [3:0]          y_pos;
		logic [3:0]          z_pos;
		logic [COLOUR_W-1:0] colour;
	} req_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] old_colour;
		logic [5:0]          face_mask;
		logic [COUNT_W-1:0]  voxel_count;
		logic                range_error;
	} rsp_t;

	typedef struct packed {
		logic [EXT_W-1:0] ex;
		logic [EXT_W-1:0] ey;
		logic [EXT_W-1:0] ez;
	} ext_t;

endpackage

@@ sv/vgfc_mem.sv @@
// single port voxel store with registered read data
module vgfc_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 addr,
	input  logic [vgfc_pkg::COLOUR_W-1:0] wdata,
	output logic [vgfc_pkg::COLOUR_W-1:0] rdata
);
	import vgfc_pkg::*;

	logic [COLOUR_W-1:0] mem [DEPTH];
	logic [COLOUR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/vgfc_cfg.sv @@
// apb size registers and effective grid extents
module vgfc_cfg #(
	parameter int X_DIM = 16,
	parameter int Y_DIM = 16,
	parameter int Z_DIM = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vgfc_pkg::APB_AW-1:0] paddr,
	input  logic [vgfc_pkg::APB_DW-1:0] pwdata,
	output logic [vgfc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output vgfc_pkg::ext_t              ext
);
	import vgfc_pkg::*;

	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_y_q;
	logic [SIZE_W-1:0] size_z_q;
	logic              wr;
	logic [1:0]        idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RST;
			size_y_q <= SIZE_RST;
			size_z_q <= SIZE_RST;
		end else if (wr) begin
			case (idx)
				REG_SIZE_X: size_x_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SIZE_X: prdata = APB_DW'(size_x_q);
			REG_SIZE_Y: prdata = APB_DW'(size_y_q);
			REG_SIZE_Z: prdata = APB_DW'(size_z_q);
			default:    prdata = '0;
		endcase
	end

	// saturate to the built grid
	always_comb begin
		ext.ex = (EXT_W'(size_x_q) > EXT_W'(X_DIM)) ? EXT_W'(X_DIM) : EXT_W'(size_x_q);
		ext.ey = (EXT_W'(size_y_q) > EXT_W'(Y_DIM)) ? EXT_W'(Y_DIM) : EXT_W'(size_y_q);
		ext.ez = (EXT_W'(size_z_q) > EXT_W'(Z_DIM)) ? EXT_W'(Z_DIM) : EXT_W'(size_z_q);
	end

endmodule

@@ sv/vgfc_ctrl.sv @@
// sequencer and shared neighbour address unit
module vgfc_ctrl #(
	parameter int X_DIM = 16,
	parameter int Y_DIM = 16,
	parameter int CELLS = 4096,
	parameter int AW    = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vgfc_pkg::ext_t                ext,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  vgfc_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output vgfc_pkg::rsp_t                rsp,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_addr,
	output logic [vgfc_pkg::COLOUR_W-1:0] mem_wdata,
	input  logic [vgfc_pkg::COLOUR_W-1:0] mem_rdata
);
	import vgfc_pkg::*;

	localparam logic [AW-1:0] STRIDE_X = AW'(1);
	localparam logic [AW-1:0] STRIDE_Y = AW'(X_DIM);
	localparam logic [AW-1:0] STRIDE_Z = AW'(X_DIM * Y_DIM);
	localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

	state_t              state_q, state_d;
	req_t                item_q;
	logic [AW-1:0]       centre_q;
	logic                err_q;
	logic [5:0]          nb_ok_q;
	logic [2:0]          nb_k_q;
	logic [COLOUR_W-1:0] old_q;
	logic [5:0]          mask_q;
	logic [COUNT_W-1:0]  count_q;
	logic [AW-1:0]       clr_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                err_c;
	logic [5:0]          ok_c;
	logic [AW-1:0]       addr_c;
	logic [2:0]          nb_sel;
	logic [AW-1:0]       delta;
	logic [AW-1:0]       nb_addr;
	logic                rd_nz;
	logic                cnt_inc;
	logic                cnt_dec;
	logic                deliver;
	logic [2:0]          hide_idx;

	assign accept  = req_valid & req_ready;
	assign rd_nz   = (mem_rdata != '0);
	assign deliver = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	assign err_c = (EXT_W'(req.x_pos) >= ext.ex) || (EXT_W'(req.y_pos) >= ext.ey) ||
	               (EXT_W'(req.z_pos) >= ext.ez);

	assign ok_c = {
		(EXT_W'(req.z_pos) + EXT_W'(1)) < ext.ez, req.z_pos != 4'd0,
		(EXT_W'(req.y_pos) + EXT_W'(1)) < ext.ey, req.y_pos != 4'd0,
		(EXT_W'(req.x_pos) + EXT_W'(1)) < ext.ex, req.x_pos != 4'd0
	};

	assign addr_c = AW'(req.z_pos) * STRIDE_Z + AW'(req.y_pos) * STRIDE_Y + AW'(req.x_pos);

	// shared neighbour address adder
	always_comb begin
		case (nb_sel[2:1])
			2'd0:    delta = STRIDE_X;
			2'd1:    delta = STRIDE_Y;
			2'd2:    delta = STRIDE_Z;
			default: delta = '0;
		endcase
		nb_addr = nb_sel[0] ? (centre_q + delta) : (centre_q - delta);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE:   if (req_valid) state_d = err_c ? ST_DONE : ST_CENTRE;
			ST_CENTRE: state_d = ST_CHECK;
			ST_CHECK:  state_d = (item_q.mode == MODE_QUERY && rd_nz) ? ST_NBR : ST_DONE;
			ST_NBR:    if (nb_k_q == NB_LAST) state_d = ST_TAIL;
			ST_TAIL:   state_d = ST_DONE;
			ST_DONE:   if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = centre_q;
		mem_wdata = '0;
		nb_sel    = nb_k_q;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_CHECK: begin
				nb_sel = '0;
				if (item_q.mode == MODE_PUT && !rd_nz && item_q.colour != '0) begin
					mem_we    = 1'b1;
					mem_wdata = item_q.colour;
					cnt_inc   = 1'b1;
				end else if (item_q.mode == MODE_DEL && rd_nz) begin
					mem_we  = 1'b1;
					cnt_dec = 1'b1;
				end else begin
					mem_addr = nb_addr;
				end
			end
			ST_NBR: begin
				mem_addr = nb_addr;
			end
			default: ;
		endcase
	end

	assign hide_idx = (state_q == ST_TAIL) ? NB_LAST : (nb_k_q - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			nb_k_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cnt_inc) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (state_q == ST_CHECK) begin
				nb_k_q <= NB_FIRST;
			end else if (state_q == ST_NBR) begin
				nb_k_q <= nb_k_q + 3'd1;
			end
			if (deliver) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req;
			centre_q <= addr_c;
			err_q    <= err_c;
			nb_ok_q  <= ok_c;
			old_q    <= '0;
			mask_q   <= '0;
		end
		if (state_q == ST_CHECK) begin
			old_q  <= mem_rdata;
			mask_q <= (item_q.mode == MODE_QUERY && rd_nz) ? MASK_ALL : '0;
		end
		if (state_q == ST_NBR || state_q == ST_TAIL) begin
			mask_q[hide_idx] <= !(nb_ok_q[hide_idx] && rd_nz);
		end
		if (deliver) begin
			rsp_q.old_colour  <= old_q;
			rsp_q.face_mask   <= mask_q;
			rsp_q.voxel_count <= count_q;
			rsp_q.range_error <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/voxel_grid_face_cull.sv @@
// top level of the voxel occupancy grid with face culling
//
// a request beat carries a mode (put, delete, face query), a cell position and a colour;
// each request gives exactly one response beat with the previous cell colour, the
// visible face mask, the running occupied count and an out of range flag.
// size_x, size_y and size_z are written over the apb port; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// all cells share one single port memory with registered read data, one access a cycle.
// an out of range request goes straight to the done state; any other has its cell read
// in the centre state and acted on in the check state, and a query of an occupied cell
// then has its six neighbours read one after another before the done state.
// req_ready is high only while the sequencer is idle, so one request is in flight;
// it rises again in the same cycle that the response turns valid.
// the response sits in an output register: a new request is taken while a response
// still waits, and a finished item only holds in its last state while rsp_ready is low.
// after reset the store is cleared by a pass that writes one cell a cycle over all
// X_DIM*Y_DIM*Z_DIM cells (4096 by default); req_ready stays low until it ends,
// apb writes are taken throughout.
module voxel_grid_face_cull #(
	parameter int X_DIM = 16,
	parameter int Y_DIM = 16,
	parameter int Z_DIM = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vgfc_pkg::APB_AW-1:0] paddr,
	input  logic [vgfc_pkg::APB_DW-1:0] pwdata,
	output logic [vgfc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  vgfc_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output vgfc_pkg::rsp_t              rsp
);
	import vgfc_pkg::*;

	localparam int CELLS = X_DIM * Y_DIM * Z_DIM;
	localparam int AW    = $clog2(CELLS);

	ext_t                ext;
	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	logic [COLOUR_W-1:0] mem_wdata;
	logic [COLOUR_W-1:0] mem_rdata;

	vgfc_cfg #(
		.X_DIM(X_DIM),
		.Y_DIM(Y_DIM),
		.Z_DIM(Z_DIM)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.ext    (ext)
	);

	vgfc_ctrl #(
		.X_DIM(X_DIM),
		.Y_DIM(Y_DIM),
		.CELLS(CELLS),
		.AW   (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ext      (ext),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	vgfc_mem #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule

@@ sv/vgfc_chk.sv @@
// port level checks of the voxel grid face cull block
module vgfc_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input vgfc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input vgfc_pkg::rsp_t rsp
);
	import vgfc_pkg::*;

	// waiting request beat holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat changed while waiting");

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed under stall");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in flight");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.range_error |-> rsp.old_colour == '0 && rsp.face_mask == '0)
		else $error("out of range response carries data");

	a_mask_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.face_mask != '0 |-> rsp.old_colour != '0)
		else $error("faces reported for an empty cell");

endmodule

bind voxel_grid_face_cull vgfc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
